/* rtl/dbr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_pkg
// Shared types and constants for the debounced button event reporter.
// ----------------------------------------------------------------------------
package dbr_pkg;

    localparam int BUTTONS    = 4;   // 1..4, one event field per button
    localparam int NUM_EVENTS = 4;   // event fields on the result beat

    localparam int LEVEL_W = 4;
    localparam int ADC_W   = 10;
    localparam int TIME_W  = 32;
    localparam int TICK_W  = 16;
    localparam int CNT_W   = TICK_W + 1;
    localparam int PER_W   = 16;

    localparam int S_TDATA_W = 48;   // 46 payload bits, byte padded
    localparam int M_TDATA_W = 24;   // 18 payload bits, byte padded
    localparam int M_TUSER_W = 1;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0] CNT_IDLE = '1;
    localparam logic [ADC_W-1:0] POT_MAX  = '1;

    typedef logic [1:0] t_code;
    localparam t_code CODE_OPEN     = 2'd0;
    localparam t_code CODE_CLOSED   = 2'd1;
    localparam t_code CODE_PRESSED  = 2'd2;
    localparam t_code CODE_RELEASED = 2'd3;

    typedef logic [NUM_EVENTS-1:0][1:0] t_codes;

    typedef enum logic [1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_POT_THRESHOLD  = 2'd1,
        REG_PERIOD_MS      = 2'd2
    } t_reg_idx;

    localparam logic [TICK_W-1:0] RST_DEBOUNCE_TICKS = 16'd50;
    localparam logic [ADC_W-1:0]  RST_POT_THRESHOLD  = 10'd4;
    localparam logic [PER_W-1:0]  RST_PERIOD_MS      = 16'd100;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [ADC_W-1:0]  pot_threshold;
        logic [PER_W-1:0]  period_ms;
    } t_cfg;

    typedef struct packed {
        t_codes codes;     // codes after this beat's debounce step
        logic   pending;   // event waiting to be reported
    } t_btn_status;

    typedef struct packed {
        t_codes           codes;
        logic [ADC_W-1:0] pot_value;
        logic             periodic;
    } t_result;

    function automatic t_code consume_code(input t_code c);
        t_code r;
        r = c;
        if (c == CODE_PRESSED) begin
            r = CODE_CLOSED;
        end else if (c == CODE_RELEASED) begin
            r = CODE_OPEN;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/debounced_button_event_reporter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// debounced_button_event_reporter_core
// Debounces four button levels and reports events, pot moves and heartbeats.
//
// Input stream (s_*): one beat per sample of button levels, pot reading and
// millisecond time. Output stream (m_*): zero or one report beat per sample,
// in sample order. Registers sit behind the APB port (pready tied high).
// An accepted beat is processed from the input register, and its report (if
// any) is registered in the report register and shows on m_* from there.
// One beat per cycle is sustained while m_tready is high; the whole
// per-sample update is one pass through the debounce and report logic.
// When the receiver stalls, the report register holds its beat, the input
// register fills, and s_tready drops once it is full. Samples that yield no
// report still need the report register free or draining to advance.
// Reset clears both stages, restores register defaults, sets the previous
// levels to all ones, stops all countdowns and clears events and history.
// ----------------------------------------------------------------------------
module debounced_button_event_reporter_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [3:0] button_levels, [13:4] adc_sample, [45:14] time_ms, [47:46] zero
    input  wire logic [dbr_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [1:0] ok_event, [3:2] back_event, [5:4] color_event, [7:6] cord_event,
    // [17:8] pot_value, [23:18] zero
    output logic      [dbr_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] periodic
    output logic      [dbr_pkg::M_TUSER_W-1:0] m_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [dbr_pkg::APB_AW-1:0]    paddr,
    input  wire logic [dbr_pkg::APB_DW-1:0]    pwdata,
    output logic      [dbr_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);
    import dbr_pkg::*;

    t_cfg        w_cfg;
    t_btn_status w_status;
    t_result     w_result;
    logic        w_report;

    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_in_levels;
    logic [ADC_W-1:0]   r_in_adc;
    logic [TIME_W-1:0]  r_in_time;
    logic               r_out_valid;
    t_result            r_out;

    logic w_advance;
    logic w_fire;
    logic w_s_beat;

    assign w_advance = !r_out_valid || m_tready;
    assign w_fire    = r_in_valid && w_advance;
    assign s_tready  = !r_in_valid || w_advance;
    assign w_s_beat  = s_tvalid && s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_beat) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_beat) begin
            r_in_levels <= s_tdata[LEVEL_W-1:0];
            r_in_adc    <= s_tdata[LEVEL_W +: ADC_W];
            r_in_time   <= s_tdata[LEVEL_W+ADC_W +: TIME_W];
        end
    end

    dbr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dbr_debounce u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_levels (r_in_levels[BUTTONS-1:0]),
        .i_ticks  (w_cfg.debounce_ticks),
        .i_report (w_report),
        .o_status (w_status)
    );

    dbr_report u_report (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_adc    (r_in_adc),
        .i_time   (r_in_time),
        .i_status (w_status),
        .i_cfg    (w_cfg),
        .o_report (w_report),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire && w_report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_report) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = M_TDATA_W'({r_out.pot_value, r_out.codes});
    assign m_tuser  = M_TUSER_W'(r_out.periodic);

    // a heartbeat report never carries an unreported press or release
    a_periodic_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.periodic) |->
            (r_out.codes[0][1] == 1'b0 && r_out.codes[1][1] == 1'b0 &&
             r_out.codes[2][1] == 1'b0 && r_out.codes[3][1] == 1'b0))
        else $error("periodic report carries a press or release");

    // any fresh press or release keeps the pending flag up
    a_event_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_status.codes[0][1] || w_status.codes[1][1] ||
         w_status.codes[2][1] || w_status.codes[3][1]) |-> w_status.pending)
        else $error("unreported event without pending flag");

    // input stage only back-pressures when it holds a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> r_in_valid)
        else $error("s_tready low with empty input register");

    // a beat leaving the input register is either reported or dropped, never held
    a_fire_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_report) |=> r_out_valid)
        else $error("report lost on the way to the output register");

endmodule
`default_nettype wire

/* rtl/dbr_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_regs
// APB configuration registers: debounce ticks, pot threshold, report period.
// ----------------------------------------------------------------------------
module dbr_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dbr_pkg::APB_AW-1:0] paddr,
    input  wire logic [dbr_pkg::APB_DW-1:0] pwdata,
    output logic      [dbr_pkg::APB_DW-1:0] prdata,
    output logic                            pready,
    output dbr_pkg::t_cfg                   o_cfg
);
    import dbr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_cfg.pot_threshold  <= RST_POT_THRESHOLD;
            r_cfg.period_ms      <= RST_PERIOD_MS;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= pwdata[TICK_W-1:0];
                REG_POT_THRESHOLD:  r_cfg.pot_threshold  <= pwdata[ADC_W-1:0];
                REG_PERIOD_MS:      r_cfg.period_ms      <= pwdata[PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DEBOUNCE_TICKS: prdata = APB_DW'(r_cfg.debounce_ticks);
            REG_POT_THRESHOLD:  prdata = APB_DW'(r_cfg.pot_threshold);
            REG_PERIOD_MS:      prdata = APB_DW'(r_cfg.period_ms);
            default:            prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

/* rtl/dbr_debounce.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_debounce
// Per-button countdown debouncers with latched press/release codes.
// ----------------------------------------------------------------------------
module dbr_debounce (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [dbr_pkg::BUTTONS-1:0] i_levels,
    input  wire logic [dbr_pkg::TICK_W-1:0]  i_ticks,
    input  wire logic                        i_report,
    output dbr_pkg::t_btn_status             o_status
);
    import dbr_pkg::*;

    logic [BUTTONS-1:0]            r_prev;
    logic [BUTTONS-1:0][CNT_W-1:0] r_cnt;
    logic [BUTTONS-1:0]            r_state;
    logic [BUTTONS-1:0][1:0]       r_code;
    logic                          r_pending;

    logic [BUTTONS-1:0][CNT_W-1:0] n_cnt;
    logic [BUTTONS-1:0]            n_state;
    logic [BUTTONS-1:0][1:0]       n_code;
    logic                          n_pending;
    logic [BUTTONS-1:0]            w_flip;
    logic                          w_changed;

    assign w_changed = (i_levels != r_prev);

    always_comb begin
        n_pending = r_pending;
        for (int i = 0; i < BUTTONS; i++) begin
            n_cnt[i] = r_cnt[i];
            w_flip[i] = 1'b0;
            if (w_changed && (i_levels[i] == r_state[i])) begin
                n_cnt[i] = CNT_W'(i_ticks);
            end
            if (n_cnt[i] != CNT_IDLE) begin
                n_cnt[i] = n_cnt[i] - 1'b1;
                w_flip[i] = (n_cnt[i] == '0) && (i_levels[i] == r_state[i]);
            end
            n_state[i] = r_state[i] ^ w_flip[i];
            n_code[i]  = r_code[i];
            if (w_flip[i]) begin
                n_code[i] = n_state[i] ? CODE_PRESSED : CODE_RELEASED;
            end
            n_pending = n_pending | w_flip[i];
        end
    end

    always_comb begin
        o_status.codes = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            o_status.codes[i] = n_code[i];
        end
        o_status.pending = n_pending;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '1;
            r_cnt     <= {BUTTONS{CNT_IDLE}};
            r_state   <= '0;
            r_code    <= {BUTTONS{CODE_OPEN}};
            r_pending <= 1'b0;
        end else if (i_fire) begin
            r_prev  <= i_levels;
            r_cnt   <= n_cnt;
            r_state <= n_state;
            for (int i = 0; i < BUTTONS; i++) begin
                r_code[i] <= i_report ? consume_code(n_code[i]) : n_code[i];
            end
            r_pending <= n_pending && !i_report;
        end
    end

endmodule
`default_nettype wire

/* rtl/dbr_report.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbr_report
// Report decision: pending event, pot move past threshold, or period expiry.
// ----------------------------------------------------------------------------
module dbr_report (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic [dbr_pkg::ADC_W-1:0]  i_adc,
    input  wire logic [dbr_pkg::TIME_W-1:0] i_time,
    input  dbr_pkg::t_btn_status            i_status,
    input  dbr_pkg::t_cfg                   i_cfg,
    output logic                            o_report,
    output dbr_pkg::t_result                o_result
);
    import dbr_pkg::*;

    logic [ADC_W-1:0]  r_last_pot;
    logic [TIME_W-1:0] r_last_time;

    logic [ADC_W-1:0]  w_pot;
    logic [ADC_W-1:0]  w_diff;
    logic [TIME_W-1:0] w_elapsed;
    logic              w_active;
    logic              w_expired;

    assign w_pot     = POT_MAX - i_adc;
    assign w_diff    = (w_pot > r_last_pot) ? (w_pot - r_last_pot) : (r_last_pot - w_pot);
    assign w_elapsed = i_time - r_last_time;
    assign w_active  = i_status.pending || (w_diff > i_cfg.pot_threshold);
    assign w_expired = w_elapsed > TIME_W'(i_cfg.period_ms);
    assign o_report  = w_active || w_expired;

    assign o_result.codes     = i_status.codes;
    assign o_result.pot_value = w_pot;
    assign o_result.periodic  = !w_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pot  <= '0;
            r_last_time <= '0;
        end else if (i_fire && o_report) begin
            r_last_pot  <= w_pot;
            r_last_time <= i_time;
        end
    end

endmodule
`default_nettype wire

/* verif/tb_debounced_button_event_reporter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_button_event_reporter_core
// Self-checking bench for the button debounce and report core.
//
// Sample beats go in on the s_* stream. A behavioral tracker follows the
// four countdowns, the debounced states, the latched event codes and the
// pot and time history, and queues the report that each sample should
// raise. Report beats on m_* are compared field by field against that
// queue. Register settings change between phases once the core has
// drained. Each phase runs with one of four mixes of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_debounced_button_event_reporter_core;

    import dbr_pkg::*;

    typedef struct {
        t_code      ok;
        t_code      back;
        t_code      color;
        t_code      cord;
        logic [9:0] pot;
        logic       periodic;
    } t_report;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [3:0] button_levels, [13:4] adc_sample, [45:14] time_ms, [47:46] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] ok, [3:2] back, [5:4] color, [7:6] cord, [17:8] pot_value
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] periodic
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    debounced_button_event_reporter_core i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 i_clk = ~i_clk;

    // register settings per phase
    int unsigned phase_ticks[8]  = '{1, 3, 7, 65535, 0, 5, 12, 2};
    int unsigned phase_thresh[8] = '{0, 1023, 4, 10, 2, 1, 100, 0};
    int unsigned phase_period[8] = '{1, 65535, 20, 100, 50, 10, 300, 65535};

    // tracker configuration
    logic [TICK_W-1:0] cfg_ticks;
    logic [ADC_W-1:0]  cfg_thresh;
    logic [PER_W-1:0]  cfg_period;

    // tracker state
    logic [LEVEL_W-1:0] prev_levels;
    logic [CNT_W-1:0]   countdown [BUTTONS];
    logic [BUTTONS-1:0] stable_state;
    t_code              latched_code [NUM_EVENTS];
    logic               event_waiting;
    logic [ADC_W-1:0]   last_pot;
    logic [TIME_W-1:0]  last_report_ms;

    logic [S_TDATA_W-1:0] sample_queue[$];
    t_report              expected_reports[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned samples_queued   = 0;
    int unsigned samples_accepted = 0;
    int unsigned reports_seen     = 0;
    int unsigned periodic_seen    = 0;
    int unsigned pressed_seen     = 0;
    int unsigned released_seen    = 0;
    int unsigned mismatches       = 0;

    // stimulus generator state
    logic [LEVEL_W-1:0] gen_levels  = '1;
    int unsigned        gen_hold    = 0;
    int                 gen_adc     = 1023;
    logic [TIME_W-1:0]  gen_time_ms = '0;

    task automatic reset_tracker();
        cfg_ticks      = RST_DEBOUNCE_TICKS;
        cfg_thresh     = RST_POT_THRESHOLD;
        cfg_period     = RST_PERIOD_MS;
        prev_levels    = LEVEL_W'((1 << BUTTONS) - 1);
        stable_state   = '0;
        event_waiting  = 1'b0;
        last_pot       = '0;
        last_report_ms = '0;
        for (int i = 0; i < BUTTONS; i++) begin
            countdown[i] = CNT_IDLE;
        end
        for (int i = 0; i < NUM_EVENTS; i++) begin
            latched_code[i] = CODE_OPEN;
        end
    endtask

    // one sample through debounce, then event/pot report, then period check
    task automatic debounce_and_report(input logic [LEVEL_W-1:0] raw_levels,
                                       input logic [ADC_W-1:0] adc,
                                       input logic [TIME_W-1:0] now_ms);
        logic [LEVEL_W-1:0] levels;
        logic [ADC_W-1:0]   pot;
        logic [ADC_W-1:0]   pot_delta;
        logic [TIME_W-1:0]  elapsed;
        logic               fire;
        logic               by_period;
        t_report            rpt;
        levels = raw_levels & LEVEL_W'((1 << BUTTONS) - 1);
        pot    = POT_MAX - adc;
        if (levels != prev_levels) begin
            for (int i = 0; i < BUTTONS; i++) begin
                if (levels[i] == stable_state[i]) begin
                    countdown[i] = CNT_W'(cfg_ticks);
                end
            end
        end
        prev_levels = levels;
        for (int i = 0; i < BUTTONS; i++) begin
            if (countdown[i] != CNT_IDLE) begin
                countdown[i] = countdown[i] - 1'b1;
                if (countdown[i] == '0 && levels[i] == stable_state[i]) begin
                    stable_state[i] = ~stable_state[i];
                    latched_code[i] = stable_state[i] ? CODE_PRESSED : CODE_RELEASED;
                    event_waiting   = 1'b1;
                end
            end
        end
        pot_delta = (pot > last_pot) ? pot - last_pot : last_pot - pot;
        elapsed   = now_ms - last_report_ms;
        fire      = 1'b0;
        by_period = 1'b0;
        if (event_waiting || pot_delta > cfg_thresh) begin
            fire = 1'b1;
        end else if (elapsed > TIME_W'(cfg_period)) begin
            fire      = 1'b1;
            by_period = 1'b1;
        end
        if (fire) begin
            rpt.ok       = latched_code[0];
            rpt.back     = latched_code[1];
            rpt.color    = latched_code[2];
            rpt.cord     = latched_code[3];
            rpt.pot      = pot;
            rpt.periodic = by_period;
            expected_reports.push_back(rpt);
            for (int i = 0; i < NUM_EVENTS; i++) begin
                if (latched_code[i] == CODE_PRESSED) begin
                    latched_code[i] = CODE_CLOSED;
                end else if (latched_code[i] == CODE_RELEASED) begin
                    latched_code[i] = CODE_OPEN;
                end
            end
            event_waiting  = 1'b0;
            last_pot       = pot;
            last_report_ms = now_ms;
        end
    endtask

    // source side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                debounce_and_report(s_tdata[3:0], s_tdata[13:4], s_tdata[45:14]);
                samples_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= sample_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // sink side
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && m_tvalid && m_tready) begin
            reports_seen++;
            periodic_seen += m_tuser[0];
            for (int i = 0; i < NUM_EVENTS; i++) begin
                if (m_tdata[2*i +: 2] == CODE_PRESSED) pressed_seen++;
                if (m_tdata[2*i +: 2] == CODE_RELEASED) released_seen++;
            end
            if (expected_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected report beat, expected none, got %h/%h",
                         $time, m_tdata, m_tuser);
            end else begin
                want = expected_reports.pop_front();
                check_field("ok_event",    want.ok,       m_tdata[1:0]);
                check_field("back_event",  want.back,     m_tdata[3:2]);
                check_field("color_event", want.color,    m_tdata[5:4]);
                check_field("cord_event",  want.cord,     m_tdata[7:6]);
                check_field("pot_value",   want.pot,      m_tdata[17:8]);
                check_field("periodic",    want.periodic, m_tuser[0]);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic queue_sample(input logic [LEVEL_W-1:0] levels,
                                input logic [ADC_W-1:0] adc,
                                input logic [TIME_W-1:0] now_ms);
        sample_queue.push_back({2'b00, now_ms, adc, levels});
        samples_queued++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE_TICKS: cfg_ticks  = value[TICK_W-1:0];
            REG_POT_THRESHOLD:  cfg_thresh = value[ADC_W-1:0];
            REG_PERIOD_MS:      cfg_period = value[PER_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
        end while (samples_accepted != samples_queued || expected_reports.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // held level patterns with bounces, pot jitter with jumps, mostly steady time
    task automatic queue_random_samples(input int unsigned count);
        logic [LEVEL_W-1:0] levels;
        int unsigned        pick;
        for (int n = 0; n < count; n++) begin
            if (gen_hold == 0) begin
                if ($urandom_range(1)) begin
                    gen_levels[$urandom_range(LEVEL_W-1)] ^= 1'b1;
                end else begin
                    gen_levels = LEVEL_W'($urandom);
                end
                if ($urandom_range(9) < 7 && cfg_ticks <= 60) begin
                    gen_hold = cfg_ticks + 1 + $urandom_range(4);
                end else begin
                    gen_hold = $urandom_range(1, 4);
                end
            end
            gen_hold--;
            levels = gen_levels;
            if ($urandom_range(99) < 5) begin
                levels = LEVEL_W'($urandom);
            end
            if ($urandom_range(99) < 10) begin
                gen_adc = $urandom_range(1023);
            end else begin
                gen_adc = gen_adc + int'($urandom_range(6)) - 3;
                if (gen_adc < 0) gen_adc = 0;
                if (gen_adc > 1023) gen_adc = 1023;
            end
            pick = $urandom_range(99);
            if (pick < 85) begin
                gen_time_ms += $urandom_range(3);
            end else if (pick < 95) begin
                gen_time_ms += $urandom_range(2 * cfg_period + 2);
            end else begin
                gen_time_ms = $urandom;
            end
            queue_sample(levels, ADC_W'(gen_adc), gen_time_ms);
        end
    endtask

    initial begin
        #1_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        reset_tracker();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: ticks 50, threshold 4, period 100
        queue_sample(4'hF, 10'd1023, 32'd0);
        queue_sample(4'h0, 10'd1023, 32'd1);
        queue_sample(4'h0, 10'd1023, 32'd101);
        queue_sample(4'h0, 10'd1023, 32'd201);
        queue_sample(4'h0, 10'd1019, 32'd202);
        queue_sample(4'h0, 10'd1018, 32'd203);
        queue_sample(4'h5, 10'd0,    32'd204);
        queue_sample(4'hA, 10'd512,  32'd205);
        queue_sample(4'h3, 10'd511,  32'd206);
        queue_sample(4'hC, 10'd1,    32'd207);
        queue_sample(4'hF, 10'd1022, 32'hFFFF_FFF0);
        queue_sample(4'hF, 10'd1022, 32'hFFFF_FFFF);
        queue_sample(4'hF, 10'd1022, 32'h0000_0050);
        queue_sample(4'hF, 10'd1022, 32'h0000_0060);
        queue_sample(4'h9, 10'd1022, 32'h0000_0061);
        queue_sample(4'h6, 10'd1022, 32'hAAAA_AAAA);
        queue_sample(4'h6, 10'd1022, 32'h5555_5555);
        gen_time_ms = 32'h5555_5555;
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_DEBOUNCE_TICKS, phase_ticks[p]);
            write_reg(REG_POT_THRESHOLD,  phase_thresh[p]);
            write_reg(REG_PERIOD_MS,      phase_period[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            queue_random_samples(185);
            wait_drained();
        end

        $display("Sent %0d samples across 9 register settings; %0d reports checked, %0d periodic.",
                 samples_accepted, reports_seen, periodic_seen);
        $display("Reports carried %0d pressed and %0d released codes.",
                 pressed_seen, released_seen);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/dbr_pkg.sv
rtl/dbr_regs.sv
rtl/dbr_debounce.sv
rtl/dbr_report.sv
rtl/debounced_button_event_reporter_core.sv
verif/tb_debounced_button_event_reporter_core.sv
